>>> design/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg: shared definitions for the bicubic plane scaler
// Plane geometry, field widths, register indexes, controller states and the
// command bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int MAX_SOURCE_WIDTH  = 256;
	localparam int MAX_SOURCE_HEIGHT = 256;
	localparam int MAX_DIMENSION     = 8192;

	localparam int COL_W       = $clog2(MAX_SOURCE_WIDTH);
	localparam int ROW_W       = $clog2(MAX_SOURCE_HEIGHT);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int PLANE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
	localparam int COORD_W     = $clog2(MAX_DIMENSION);

	localparam int PIX_W      = 8;
	localparam int SIZE_W     = 9;
	localparam int STEP_W     = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	// Source position in Q17, offset by one pixel so it never goes negative.
	localparam int POS_W  = COORD_W + 1 + STEP_W;
	localparam int POS_FB = 17;
	localparam int IDX_W  = POS_W - POS_FB;
	localparam int FRAC_W = 8;

	localparam int WGT_W = 16;
	localparam int ACC_W = 40;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(256);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(256);
	localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(21845);

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_SOURCE_WIDTH    = 2'd0;
	localparam cfg_idx_t REG_SOURCE_HEIGHT   = 2'd1;
	localparam cfg_idx_t REG_STEP_HORIZONTAL = 2'd2;
	localparam cfg_idx_t REG_STEP_VERTICAL   = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [3:0] READ_LAST  = 4'd15;
	localparam logic [3:0] DRAIN_LAST = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_WA2,
		ST_WA3,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} bps_state_t;

	typedef struct packed {
		logic       capture;
		logic       load_we;
		logic       read_en;
		logic [1:0] tap_row;
		logic [1:0] tap_col;
		logic       acc_clear;
		logic       out_load;
	} bps_cmd_t;

endpackage

>>> design/bps_ctrl.sv
// ----------------------------------------------------------------------------
// bps_ctrl: sequencing controller of the bicubic plane scaler
// Accepts input beats, steps a query through position, weight setup, sixteen
// tap reads and pipeline drain, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	output logic              out_valid,
	input  logic              out_ready,
	output bps_pkg::bps_cmd_t cmd
);
	import bps_pkg::*;

	bps_state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == OP_QUERY) begin
						cmd.capture = 1'b1;
						state_d     = ST_POS;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_POS: state_d = ST_WA2;
			ST_WA2: state_d = ST_WA3;
			ST_WA3: begin
				cmd.acc_clear = 1'b1;
				cnt_d         = '0;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.read_en = 1'b1;
				cmd.tap_row = cnt_q[3:2];
				cmd.tap_col = cnt_q[1:0];
				if (cnt_q == READ_LAST) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == DRAIN_LAST) begin
					cnt_d   = '0;
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_FINISH: begin
				// Hold the finished sum until the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/bps_datapath.sv
// ----------------------------------------------------------------------------
// bps_datapath: storage and arithmetic of the bicubic plane scaler
// Holds the configuration registers and the source plane, maps coordinates
// to clamped taps and Q14 weights, and runs the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module bps_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bps_pkg::bps_cmd_t            cmd,
	input  logic                         cfg_valid,
	input  bps_pkg::cfg_idx_t            cfg_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [bps_pkg::COORD_W-1:0]  column,
	input  logic [bps_pkg::COORD_W-1:0]  row,
	input  logic [bps_pkg::PIX_W-1:0]    pixel_in,
	output logic [bps_pkg::PIX_W-1:0]    pixel_out,
	output logic                         saturated
);
	import bps_pkg::*;

	typedef logic [3:0][WGT_W-1:0] wgt_set_t;
	localparam int V_W = IDX_W + 2;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << 27);
	localparam logic [POS_W-1:0] POS_BIAS = POS_W'(65536);

	// Tap index k-1 relative to the floor index, clamped to the plane edge.
	function automatic logic [SIZE_W-1:0] clamp_tap(input logic [IDX_W-1:0] base,
			input logic [1:0] k, input logic [SIZE_W-1:0] lim);
		logic signed [V_W-1:0] v;
		logic signed [V_W-1:0] lim_s;
		v     = signed'({2'b00, base}) + signed'(V_W'(k)) - signed'(V_W'(2));
		lim_s = signed'(V_W'(lim));
		if (v < 0) begin
			return '0;
		end else if (v >= lim_s) begin
			return lim - SIZE_W'(1);
		end else begin
			return v[SIZE_W-1:0];
		end
	endfunction

	// Catmull-Rom weights in Q14; the center-left tap takes the remainder.
	function automatic wgt_set_t calc_weights(input logic [FRAC_W-1:0] a,
			input logic [2*FRAC_W-1:0] a2, input logic [3*FRAC_W-1:0] a3);
		logic signed [31:0] sa, sa2, sa3, n0, n2, n3, w0, w1, w2, w3;
		wgt_set_t r;
		sa  = signed'(32'(a));
		sa2 = signed'(32'(a2));
		sa3 = signed'(32'(a3));
		n0  = -sa3 + (sa2 <<< 9) - (sa <<< 16);
		n2  = -(sa3 + (sa3 <<< 1)) + (sa2 <<< 10) + (sa <<< 16);
		n3  = sa3 - (sa2 <<< 8);
		w0  = (n0 + 32'sd1024) >>> 11;
		w2  = (n2 + 32'sd1024) >>> 11;
		w3  = (n3 + 32'sd1024) >>> 11;
		w1  = 32'sd16384 - w0 - w2 - w3;
		r[0] = w0[WGT_W-1:0];
		r[1] = w1[WGT_W-1:0];
		r[2] = w2[WGT_W-1:0];
		r[3] = w3[WGT_W-1:0];
		return r;
	endfunction

	logic [SIZE_W-1:0] src_w_q, src_h_q;
	logic [STEP_W-1:0] step_h_q, step_v_q;
	logic [SIZE_W-1:0] eff_w, eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= WIDTH_RESET;
			src_h_q  <= HEIGHT_RESET;
			step_h_q <= STEP_RESET;
			step_v_q <= STEP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:    src_w_q  <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_HEIGHT:   src_h_q  <= cfg_data[SIZE_W-1:0];
				REG_STEP_HORIZONTAL: step_h_q <= cfg_data[STEP_W-1:0];
				REG_STEP_VERTICAL:   step_v_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// A size of zero behaves as one, anything larger than the plane as the plane.
	always_comb begin
		if (src_w_q == '0) begin
			eff_w = SIZE_W'(1);
		end else if (src_w_q > SIZE_W'(MAX_SOURCE_WIDTH)) begin
			eff_w = SIZE_W'(MAX_SOURCE_WIDTH);
		end else begin
			eff_w = src_w_q;
		end
		if (src_h_q == '0) begin
			eff_h = SIZE_W'(1);
		end else if (src_h_q > SIZE_W'(MAX_SOURCE_HEIGHT)) begin
			eff_h = SIZE_W'(MAX_SOURCE_HEIGHT);
		end else begin
			eff_h = src_h_q;
		end
	end

	// Query coordinates
	logic [COORD_W-1:0] col_q, row_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= column;
			row_q <= row;
		end
	end

	// Position (2d+1)*step + 2^16: floor index is the upper part minus one.
	logic [POS_W-1:0] pos_x_s1, pos_y_s1;
	always_ff @(posedge clk) begin
		pos_x_s1 <= POS_W'({col_q, 1'b1}) * POS_W'(step_h_q) + POS_BIAS;
		pos_y_s1 <= POS_W'({row_q, 1'b1}) * POS_W'(step_v_q) + POS_BIAS;
	end

	logic [IDX_W-1:0]  base_x, base_y;
	logic [FRAC_W-1:0] frac_x, frac_y;
	assign base_x = pos_x_s1[POS_W-1:POS_FB];
	assign base_y = pos_y_s1[POS_W-1:POS_FB];
	assign frac_x = pos_x_s1[POS_FB-1:POS_FB-FRAC_W];
	assign frac_y = pos_y_s1[POS_FB-1:POS_FB-FRAC_W];

	logic [3:0][COL_W-1:0] tap_x_q;
	logic [3:0][ROW_W-1:0] tap_y_q;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			tap_x_q[k] <= COL_W'(clamp_tap(base_x, 2'(k), eff_w));
			tap_y_q[k] <= ROW_W'(clamp_tap(base_y, 2'(k), eff_h));
		end
	end

	// Powers of the fraction, one multiplication per stage.
	logic [FRAC_W-1:0]   ax_s2, ay_s2, ax_s3, ay_s3;
	logic [2*FRAC_W-1:0] ax2_s2, ay2_s2, ax2_s3, ay2_s3;
	logic [3*FRAC_W-1:0] ax3_s3, ay3_s3;
	wgt_set_t            wx_q, wy_q;

	always_ff @(posedge clk) begin
		ax_s2  <= frac_x;
		ay_s2  <= frac_y;
		ax2_s2 <= frac_x * frac_x;
		ay2_s2 <= frac_y * frac_y;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
		ax2_s3 <= ax2_s2;
		ay2_s3 <= ay2_s2;
		ax3_s3 <= (3*FRAC_W)'(ax2_s2) * (3*FRAC_W)'(ax_s2);
		ay3_s3 <= (3*FRAC_W)'(ay2_s2) * (3*FRAC_W)'(ay_s2);
		wx_q   <= calc_weights(ax_s3, ax2_s3, ax3_s3);
		wy_q   <= calc_weights(ay_s3, ay2_s3, ay3_s3);
	end

	// Source plane, one port: loads write, queries read.
	logic [PIX_W-1:0]  plane_mem [PLANE_DEPTH];
	logic [PIX_W-1:0]  rd_data_s1;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              wr_in_plane;

	assign rd_addr     = {tap_y_q[cmd.tap_row], tap_x_q[cmd.tap_col]};
	assign wr_addr     = {row[ROW_W-1:0], column[COL_W-1:0]};
	assign wr_in_plane = (column < COORD_W'(MAX_SOURCE_WIDTH))
	                  && (row < COORD_W'(MAX_SOURCE_HEIGHT));

	always_ff @(posedge clk) begin
		if (cmd.load_we && wr_in_plane) begin
			plane_mem[wr_addr] <= pixel_in;
		end
		if (cmd.read_en) begin
			rd_data_s1 <= plane_mem[rd_addr];
		end
	end

	// Multiply-accumulate pipeline: horizontal weight, vertical weight, sum.
	logic                            v_s1, v_s2, v_s3;
	logic [1:0]                      kx_s1, ky_s1, ky_s2;
	logic signed [WGT_W+PIX_W:0]     prod1_s2;
	logic signed [ACC_W-1:0]         prod2_s3;
	logic signed [ACC_W-1:0]         acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.read_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		kx_s1    <= cmd.tap_col;
		ky_s1    <= cmd.tap_row;
		ky_s2    <= ky_s1;
		prod1_s2 <= signed'(wx_q[kx_s1]) * signed'({1'b0, rd_data_s1});
		prod2_s3 <= prod1_s2 * signed'(wy_q[ky_s2]);
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + prod2_s3;
		end
	end

	// Round to nearest and saturate into the pixel range.
	logic signed [ACC_W-1:0] rsum, rshift;
	assign rsum   = acc_q + ROUND_HALF;
	assign rshift = rsum >>> 28;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (rsum < 0) begin
				pixel_out <= '0;
				saturated <= 1'b1;
			end else if (rshift > ACC_W'(255)) begin
				pixel_out <= '1;
				saturated <= 1'b1;
			end else begin
				pixel_out <= rshift[PIX_W-1:0];
				saturated <= 1'b0;
			end
		end
	end

endmodule

>>> design/bicubic_plane_scaler_top.sv
// ----------------------------------------------------------------------------
// bicubic_plane_scaler_top: Catmull-Rom bicubic scaler over a stored plane
// Input beats either load one source pixel or query one destination pixel.
// A load beat writes the 256x256 source plane at (row, column); columns or
// rows outside the plane are dropped. A load produces no output beat and
// the block is ready again in the next cycle, so loads stream one per cycle.
// A query beat maps the destination coordinates through the horizontal and
// vertical steps, builds Q14 weights and reads the sixteen neighbors one per
// cycle through the single plane port, then rounds and saturates the sum.
// A query closes the input until its result is loaded into the output
// register, so a new query is not taken before the last one is through.
// A query's duration is set mostly by the sixteen tap reads on the one
// memory port, with position and weight setup before them, multiply drain
// after them and the loading of the output register at the end.
// The next beat is accepted as soon as the result sits in the output
// register, even while the receiver stalls it; a second query then waits in
// its final step until the output register is free.
// Configuration writes are taken in any cycle and must occur while idle.
// Reset restores the register defaults; the plane keeps no reset value and
// must be loaded before it is queried.
// ----------------------------------------------------------------------------
module bicubic_plane_scaler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  bps_pkg::cfg_idx_t               cfg_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [bps_pkg::COORD_W-1:0]     column,
	input  logic [bps_pkg::COORD_W-1:0]     row,
	input  logic [bps_pkg::PIX_W-1:0]       pixel_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bps_pkg::PIX_W-1:0]       pixel_out,
	output logic                            saturated
);
	import bps_pkg::*;

	bps_cmd_t cmd;

	assign cfg_ready = 1'b1;

	bps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bps_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.column    (column),
		.row       (row),
		.pixel_in  (pixel_in),
		.pixel_out (pixel_out),
		.saturated (saturated)
	);

	// The plane port never reads while a load beat could be writing it.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.read_en && in_ready))
		else $error("plane read issued while input is open");

	// A new output beat only appears after the controller loaded a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("output valid rose without a result load");

	// An accepted query closes the input until it is finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_QUERY) |=> !in_ready)
		else $error("input still open after a query beat");

	// A load beat leaves the block ready for the next beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_LOAD) |=> in_ready)
		else $error("input closed after a load beat");

endmodule

>>> tb/bicubic_plane_scaler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_plane_scaler_top_tb: self-checking bench for the bicubic scaler
// Streams pixel loads and destination queries over valid/ready, predicts each
// output beat with an independent fixed-point Catmull-Rom model or a directed
// value, and compares field by field. Plane size and step registers are swept
// between idle phases; both sides stall at random save in the final third.
// ----------------------------------------------------------------------------
module bicubic_plane_scaler_top_tb;
	import bps_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int STEP_MAX     = 262144;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             sat;
	} pixel_res_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_LOAD,
		ROW_QUERY
	} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		cfg_idx_t                idx;
		logic [CFG_DATA_W-1:0]   data;
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic [PIX_W-1:0]        pix;
		bit                      typed;
		pixel_res_t              want;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = REG_SOURCE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  operation = OP_LOAD;
	logic [COORD_W-1:0]    column    = '0;
	logic [COORD_W-1:0]    row       = '0;
	logic [PIX_W-1:0]      pixel_in  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic                  saturated;

	// Shadow of the plane and registers as the block should hold them.
	logic [PIX_W-1:0]  plane_img   [PLANE_DEPTH];
	bit                plane_known [PLANE_DEPTH];
	logic [SIZE_W-1:0] cur_width   = WIDTH_RESET;
	logic [SIZE_W-1:0] cur_height  = HEIGHT_RESET;
	logic [STEP_W-1:0] cur_step_h  = STEP_RESET;
	logic [STEP_W-1:0] cur_step_v  = STEP_RESET;
	pixel_res_t        pending_q[$];

	int send_idle_pct = 14;
	int recv_idle_pct = 62;
	int errors        = 0;
	int checked       = 0;
	int loads_sent    = 0;
	int queries_sent  = 0;
	int cfg_writes    = 0;
	int phases        = 0;
	int counted_items = 0;
	int cycles        = 0;

	bicubic_plane_scaler_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.column    (column),
		.row       (row),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.saturated (saturated)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Round n / 2048 to nearest with ties upward; the bias keeps the
	// truncating division on the positive side.
	function automatic longint round_q11(longint n);
		longint bias;
		bias = longint'(2048) << 20;
		return (n + 1024 + bias) / 2048 - bias / 2048;
	endfunction

	function automatic void tap_weights(input int unsigned f, output longint w[4]);
		longint a;
		longint a2;
		longint a3;
		a  = f;
		a2 = a * a;
		a3 = a2 * a;
		w[0] = round_q11(-a3 + 512 * a2 - 65536 * a);
		w[2] = round_q11(-3 * a3 + 1024 * a2 + 65536 * a);
		w[3] = round_q11(a3 - 256 * a2);
		w[1] = 16384 - w[0] - w[2] - w[3];
	endfunction

	// Centre-aligned source position in Q17, split into floor index and the
	// top eight fraction bits.
	function automatic void split_coord(input logic [COORD_W-1:0] d,
			input logic [STEP_W-1:0] step, output longint base,
			output int unsigned frac);
		longint biased;
		biased = (2 * longint'(d) + 1) * longint'(step) - 65536 + (longint'(1) << 17);
		base   = (biased >>> 17) - 1;
		frac   = int'((biased >>> 9) & 255);
	endfunction

	function automatic int unsigned clamp_edge(longint v, int unsigned lim);
		if (v < 0)
			return 0;
		if (v >= longint'(lim))
			return lim - 1;
		return int'(v);
	endfunction

	function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned max_v);
		if (v == 0)
			return 1;
		return (v > max_v) ? max_v : v;
	endfunction

	function automatic void find_taps(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			output int unsigned tx[4], output int unsigned ty[4],
			output longint wx[4], output longint wy[4]);
		longint      bx;
		longint      by;
		int unsigned fx;
		int unsigned fy;
		int unsigned w;
		int unsigned h;
		w = eff_size(cur_width, MAX_SOURCE_WIDTH);
		h = eff_size(cur_height, MAX_SOURCE_HEIGHT);
		split_coord(x, cur_step_h, bx, fx);
		split_coord(y, cur_step_v, by, fy);
		tap_weights(fx, wx);
		tap_weights(fy, wy);
		for (int k = 0; k < 4; k++) begin
			tx[k] = clamp_edge(bx + k - 1, w);
			ty[k] = clamp_edge(by + k - 1, h);
		end
	endfunction

	function automatic pixel_res_t interpolate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		int unsigned tx[4];
		int unsigned ty[4];
		longint      wx[4];
		longint      wy[4];
		longint      acc;
		pixel_res_t  res;
		find_taps(x, y, tx, ty, wx, wy);
		acc = 0;
		for (int ky = 0; ky < 4; ky++)
			for (int kx = 0; kx < 4; kx++)
				acc += wy[ky] * wx[kx] *
					longint'(plane_img[ty[ky] * MAX_SOURCE_WIDTH + tx[kx]]);
		acc += longint'(1) << 27;
		if (acc < 0) begin
			res.pix = '0;
			res.sat = 1'b1;
		end else if ((acc >>> 28) > 255) begin
			res.pix = '1;
			res.sat = 1'b1;
		end else begin
			res.pix = PIX_W'(acc >>> 28);
			res.sat = 1'b0;
		end
		return res;
	endfunction

	// High-contrast content so that the kernel overshoot saturates often.
	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(9)) inside
			[0:2]:   return '0;
			[3:5]:   return '1;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(9))
			0: return 0;
			1: return 256;
			2: return $urandom_range(257, 511);
			3: return $urandom_range(1, 256);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int unsigned pick_step();
		case ($urandom_range(11))
			0: return 0;
			1: return STEP_MAX;
			2: return 1;
			3: return $urandom_range(0, (1 << STEP_W) - 1);
			4: return 65536;
			default: return $urandom_range(8192, 131072);
		endcase
	endfunction

	// Destination coordinate that mostly lands inside the source plane.
	function automatic logic [COORD_W-1:0] pick_dest(logic [STEP_W-1:0] step, int unsigned lim);
		longint span;
		if (step == 0 || $urandom_range(3) == 0)
			return COORD_W'($urandom_range(MAX_DIMENSION - 1));
		span = (longint'(lim) + 2) * 65536 / step;
		if (span > MAX_DIMENSION - 1)
			span = MAX_DIMENSION - 1;
		return COORD_W'($urandom_range(int'(span)));
	endfunction

	function automatic stim_row_t stim(row_kind_t kind, int unsigned a, int unsigned b,
			int unsigned c = 0, bit typed = 0, int unsigned wp = 0, bit ws = 0);
		stim_row_t r;
		r.kind     = kind;
		r.idx      = cfg_idx_t'(a);
		r.data     = CFG_DATA_W'(b);
		r.x        = COORD_W'(a);
		r.y        = COORD_W'(b);
		r.pix      = PIX_W'(c);
		r.typed    = typed;
		r.want.pix = PIX_W'(wp);
		r.want.sat = ws;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_beat(input logic op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix,
			input bit typed, input pixel_res_t want);
		bit in_plane;
		in_plane = (x < MAX_SOURCE_WIDTH) && (y < MAX_SOURCE_HEIGHT);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		column    <= x;
		row       <= y;
		pixel_in  <= pix;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == OP_LOAD) begin
			if (in_plane) begin
				plane_img[y * MAX_SOURCE_WIDTH + x]   = pix;
				plane_known[y * MAX_SOURCE_WIDTH + x] = 1'b1;
			end
			loads_sent++;
			counted_items++;
		end else begin
			pending_q.push_back(typed ? want : interpolate(x, y));
			queries_sent++;
			counted_items++;
		end
		@(negedge clk);
	endtask

	// Every neighbor a query reads must hold a written pixel first.
	task automatic fill_taps(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int unsigned tx[4];
		int unsigned ty[4];
		longint      wx[4];
		longint      wy[4];
		pixel_res_t  none;
		none = '0;
		find_taps(x, y, tx, ty, wx, wy);
		for (int ky = 0; ky < 4; ky++)
			for (int kx = 0; kx < 4; kx++)
				if (!plane_known[ty[ky] * MAX_SOURCE_WIDTH + tx[kx]])
					send_beat(OP_LOAD, COORD_W'(tx[kx]), COORD_W'(ty[ky]),
						pick_pixel(), 1'b0, none);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_SOURCE_WIDTH:    cur_width  = val[SIZE_W-1:0];
			REG_SOURCE_HEIGHT:   cur_height = val[SIZE_W-1:0];
			REG_STEP_HORIZONTAL: cur_step_h = val[STEP_W-1:0];
			REG_STEP_VERTICAL:   cur_step_v = val[STEP_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_result
		pixel_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: output beat with nothing pending, actual pixel_out %0d saturated %0d",
					$time, pixel_out, saturated);
				errors++;
			end else begin
				want = pending_q.pop_front();
				checked++;
				if (pixel_out !== want.pix) begin
					$display("%0t: pixel_out mismatch, expected %0d, actual %0d",
						$time, want.pix, pixel_out);
					errors++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated mismatch, expected %0d, actual %0d",
						$time, want.sat, saturated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d results pending", $time, pending_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t          dir_rows[$];
		pixel_res_t         none;
		int                 directed_items;
		int                 done;
		int unsigned        w_lim;
		int unsigned        h_lim;
		int unsigned        pick;
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;

		none = '0;

		// Reset registers: a query at the origin reads only the top-left 2x2.
		dir_rows.push_back(stim(ROW_LOAD, 0, 0, 100));
		dir_rows.push_back(stim(ROW_LOAD, 1, 0, 100));
		dir_rows.push_back(stim(ROW_LOAD, 0, 1, 100));
		dir_rows.push_back(stim(ROW_LOAD, 1, 1, 100));
		dir_rows.push_back(stim(ROW_QUERY, 0, 0, 0, 1, 100, 0));
		// Zero sizes act as one pixel, so every tap is the origin.
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_WIDTH, 0));
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_HEIGHT, 0));
		dir_rows.push_back(stim(ROW_LOAD, 0, 0, 255));
		dir_rows.push_back(stim(ROW_QUERY, 8191, 8191, 0, 1, 255, 0));
		dir_rows.push_back(stim(ROW_LOAD, 0, 0, 0));
		dir_rows.push_back(stim(ROW_CFG, REG_STEP_HORIZONTAL, 0));
		dir_rows.push_back(stim(ROW_CFG, REG_STEP_VERTICAL, STEP_MAX));
		dir_rows.push_back(stim(ROW_QUERY, 8191, 0, 0, 1, 0, 0));
		// Oversized plane registers, and loads that fall outside the plane.
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_WIDTH, 511));
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_HEIGHT, 300));
		dir_rows.push_back(stim(ROW_LOAD, 256, 0, 77));
		dir_rows.push_back(stim(ROW_LOAD, 0, 256, 77));
		dir_rows.push_back(stim(ROW_LOAD, 8191, 8191, 77));
		dir_rows.push_back(stim(ROW_QUERY, 8191, 8191));
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_WIDTH, 1));
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_HEIGHT, 1));
		dir_rows.push_back(stim(ROW_QUERY, 5, 5, 0, 1, 0, 0));
		// Half-pixel phase on a 4x1 plane: edge-heavy rows under- and overshoot.
		dir_rows.push_back(stim(ROW_CFG, REG_SOURCE_WIDTH, 4));
		dir_rows.push_back(stim(ROW_CFG, REG_STEP_HORIZONTAL, STEP_MAX));
		dir_rows.push_back(stim(ROW_LOAD, 0, 0, 255));
		dir_rows.push_back(stim(ROW_LOAD, 1, 0, 0));
		dir_rows.push_back(stim(ROW_LOAD, 2, 0, 0));
		dir_rows.push_back(stim(ROW_LOAD, 3, 0, 255));
		dir_rows.push_back(stim(ROW_QUERY, 0, 0, 0, 1, 0, 1));
		dir_rows.push_back(stim(ROW_LOAD, 0, 0, 0));
		dir_rows.push_back(stim(ROW_LOAD, 1, 0, 255));
		dir_rows.push_back(stim(ROW_LOAD, 2, 0, 255));
		dir_rows.push_back(stim(ROW_LOAD, 3, 0, 0));
		dir_rows.push_back(stim(ROW_QUERY, 0, 0, 0, 1, 255, 1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: begin
					wait_idle();
					write_reg(dir_rows[i].idx, dir_rows[i].data);
				end
				ROW_LOAD: send_beat(OP_LOAD, dir_rows[i].x, dir_rows[i].y,
					dir_rows[i].pix, 1'b0, none);
				default: begin
					fill_taps(dir_rows[i].x, dir_rows[i].y);
					send_beat(OP_QUERY, dir_rows[i].x, dir_rows[i].y, dir_rows[i].pix,
						dir_rows[i].typed, dir_rows[i].want);
				end
			endcase
		end

		directed_items = counted_items;
		while (counted_items < directed_items + RANDOM_ITEMS) begin
			done = counted_items - directed_items;
			if (done < RANDOM_ITEMS / 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 62;
			end else if (done < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 62;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_idle();
			write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(pick_size()));
			write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(pick_size()));
			write_reg(REG_STEP_HORIZONTAL, CFG_DATA_W'(pick_step()));
			write_reg(REG_STEP_VERTICAL, CFG_DATA_W'(pick_step()));
			phases++;
			w_lim = eff_size(cur_width, MAX_SOURCE_WIDTH);
			h_lim = eff_size(cur_height, MAX_SOURCE_HEIGHT);
			repeat ($urandom_range(20, 80)) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					qx = pick_dest(cur_step_h, w_lim);
					qy = pick_dest(cur_step_v, h_lim);
					fill_taps(qx, qy);
					send_beat(OP_QUERY, qx, qy, PIX_W'($urandom_range(255)), 1'b0, none);
				end else if (pick < 85) begin
					send_beat(OP_LOAD, COORD_W'($urandom_range(w_lim - 1)),
						COORD_W'($urandom_range(h_lim - 1)), pick_pixel(), 1'b0, none);
				end else if (pick < 90) begin
					send_beat(OP_LOAD, COORD_W'($urandom_range(MAX_SOURCE_WIDTH - 1)),
						COORD_W'($urandom_range(MAX_SOURCE_HEIGHT - 1)), pick_pixel(),
						1'b0, none);
				end else if ($urandom_range(1)) begin
					send_beat(OP_LOAD,
						COORD_W'($urandom_range(MAX_SOURCE_WIDTH, MAX_DIMENSION - 1)),
						COORD_W'($urandom_range(MAX_DIMENSION - 1)),
						PIX_W'($urandom_range(255)), 1'b0, none);
				end else begin
					send_beat(OP_LOAD, COORD_W'($urandom_range(MAX_DIMENSION - 1)),
						COORD_W'($urandom_range(MAX_SOURCE_HEIGHT, MAX_DIMENSION - 1)),
						PIX_W'($urandom_range(255)), 1'b0, none);
				end
			end
		end

		wait_idle();
		$display("Covered %0d load beats and %0d query beats, %0d results checked.",
			loads_sent, queries_sent, checked);
		$display("Swept %0d register settings over %0d writes, zero and oversized values included.",
			phases, cfg_writes);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
